[design/assert_macros.svh]
// Assertion macros shared by the soft bit combiner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CSB_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define CSB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSB_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define CSB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[design/csb_pkg.sv]
// Types and constants of the soft bit combiner.
package csb_pkg;

    localparam int BUFFER_DEPTH = 16384;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] DEFAULT_LIMIT = 8'd3;
    localparam logic [7:0] COUNT_MAX     = 8'hFF;
    localparam logic signed [15:0] SOFT_MAX = 16'sd127;
    localparam logic signed [15:0] SOFT_MIN = -16'sd127;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_RESET = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_INVALID_ARG   = 3'd1,
        ST_INVALID_SIZE  = 3'd2,
        ST_BUSY          = 3'd3,
        ST_INVALID_STATE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_ADD   = 2'd2,
        OP_READ  = 2'd3
    } t_op_kind;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_EXEC = 1'b1
    } t_back_state;

    typedef struct packed {
        t_cmd               command;
        logic [14:0]        frame_length;
        logic signed [7:0]  soft_value;
        logic [13:0]        read_index;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic signed [7:0]  combined_value;
        logic [7:0]         combine_count;
        logic               can_add;
        logic               transmission_done;
    } t_result;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        t_op_kind           kind;
        logic [ADDR_W-1:0]  addr;
        logic signed [7:0]  soft_bit;
        t_status            status;
        logic [7:0]         count;
        logic               can_add;
        logic               done;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

[design/chase_soft_bit_combiner_top.sv]
// Top level of the chase combining soft bit accumulator.
// Each command item returns exactly one result, shown for one cycle with o_strobe
// high; the receiver cannot stall it. The back end takes one item at a time, in
// order: a registered read of the accumulator memory, then add, write and result.
// It pops the next item only once the last one is done. A two-entry queue lets
// start be taken while the back end works; busy is high while that queue is full.
// combine_limit is written through the configuration channel, which is always
// ready.
module chase_soft_bit_combiner_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  csb_pkg::t_in      i_item,
    output logic              o_strobe,
    output csb_pkg::t_result  o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_data
);

    csb_pkg::t_op         front_op;
    csb_pkg::t_op         head_op;
    csb_pkg::t_queue_stat qstat;
    logic                 accept;
    logic                 pop;

    assign busy        = qstat.full;
    assign accept      = start && !qstat.full;
    assign o_cfg_ready = 1'b1;

    csb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_op       (front_op)
    );

    csb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_op    (front_op),
        .i_pop   (pop),
        .o_op    (head_op),
        .o_stat  (qstat)
    );

    csb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (head_op),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

[design/csb_queue.sv]
// Two-entry queue of classified items between front and back.
`include "assert_macros.svh"

module csb_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  csb_pkg::t_op       i_op,
    input  logic               i_pop,
    output csb_pkg::t_op       o_op,
    output csb_pkg::t_queue_stat o_stat
);

    csb_pkg::t_op                r_slot [csb_pkg::QUEUE_DEPTH];
    logic [csb_pkg::QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [csb_pkg::QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [csb_pkg::QPTR_W:0]    r_cnt, n_cnt;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt + (csb_pkg::QPTR_W+1)'(i_push) - (csb_pkg::QPTR_W+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    assign o_op         = r_slot[r_rd_ptr];
    assign o_stat.full  = (r_cnt == (csb_pkg::QPTR_W+1)'(csb_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    `CSB_ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_cnt != '0, "pop from empty queue")
    `CSB_ASSERT_NEXT(a_fill_grows, i_clk, i_rst_n, i_push && !i_pop, r_cnt == $past(r_cnt) + 1'b1, "queue fill count did not grow on push")

endmodule

[design/csb_front.sv]
// Front end: checks each command against the window state and classifies it.
`include "assert_macros.svh"

module csb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  csb_pkg::t_in  i_item,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    output csb_pkg::t_op  o_op
);

    logic [7:0]  r_limit;
    logic [7:0]  r_count, n_count;
    logic [14:0] r_exp_len, n_exp_len;
    logic [14:0] r_wpos, n_wpos;
    logic        r_open, n_open;

    logic [7:0]  eff_limit;
    logic [14:0] wpos_inc;

    assign eff_limit = (r_limit == 8'd0) ? csb_pkg::DEFAULT_LIMIT : r_limit;
    assign wpos_inc  = r_wpos + 15'd1;

    always_comb begin
        n_count   = r_count;
        n_exp_len = r_exp_len;
        n_wpos    = r_wpos;
        n_open    = r_open;
        o_op      = '0;
        o_op.kind     = csb_pkg::OP_NONE;
        o_op.status   = csb_pkg::ST_OK;
        o_op.soft_bit = i_item.soft_value;
        case (i_item.command)
            csb_pkg::CMD_START: begin
                if (r_open) begin
                    o_op.status = csb_pkg::ST_INVALID_STATE;
                end else if (i_item.frame_length == 15'd0) begin
                    o_op.status = csb_pkg::ST_INVALID_ARG;
                end else if (32'(i_item.frame_length) > 32'(csb_pkg::BUFFER_DEPTH)) begin
                    o_op.status = csb_pkg::ST_INVALID_SIZE;
                end else if (r_count >= eff_limit) begin
                    o_op.status = csb_pkg::ST_BUSY;
                end else if (r_count != 8'd0 && i_item.frame_length != r_exp_len) begin
                    o_op.status = csb_pkg::ST_INVALID_SIZE;
                end else begin
                    if (r_count == 8'd0) begin
                        n_exp_len = i_item.frame_length;
                    end
                    n_wpos = '0;
                    n_open = 1'b1;
                end
            end
            csb_pkg::CMD_ADD: begin
                if (!r_open || r_wpos >= r_exp_len
                        || 32'(r_wpos) >= 32'(csb_pkg::BUFFER_DEPTH)) begin
                    o_op.status = csb_pkg::ST_INVALID_STATE;
                end else begin
                    // The first transmission overwrites stale contents.
                    o_op.kind = (r_count == 8'd0) ? csb_pkg::OP_WRITE : csb_pkg::OP_ADD;
                    o_op.addr = r_wpos[csb_pkg::ADDR_W-1:0];
                    n_wpos    = wpos_inc;
                    if (wpos_inc >= r_exp_len) begin
                        n_open    = 1'b0;
                        o_op.done = 1'b1;
                        if (r_count != csb_pkg::COUNT_MAX) begin
                            n_count = r_count + 8'd1;
                        end
                    end
                end
            end
            csb_pkg::CMD_READ: begin
                if (r_count == 8'd0 || r_exp_len == 15'd0) begin
                    o_op.status = csb_pkg::ST_INVALID_STATE;
                end else if (15'(i_item.read_index) >= r_exp_len) begin
                    o_op.status = csb_pkg::ST_INVALID_SIZE;
                end else begin
                    o_op.kind = csb_pkg::OP_READ;
                    o_op.addr = csb_pkg::ADDR_W'(i_item.read_index);
                end
            end
            csb_pkg::CMD_RESET: begin
                n_count   = '0;
                n_exp_len = '0;
                n_wpos    = '0;
                n_open    = 1'b0;
            end
            default: begin
                o_op.status = csb_pkg::ST_OK;
            end
        endcase
        o_op.count   = n_count;
        o_op.can_add = (n_count < eff_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= csb_pkg::DEFAULT_LIMIT;
            r_count   <= '0;
            r_exp_len <= '0;
            r_wpos    <= '0;
            r_open    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_accept) begin
                r_count   <= n_count;
                r_exp_len <= n_exp_len;
                r_wpos    <= n_wpos;
                r_open    <= n_open;
            end
        end
    end

    `CSB_ASSERT_SAME(a_wpos_ok, i_clk, i_rst_n, r_open, r_wpos < r_exp_len, "position past frame")

endmodule

[design/csb_back.sv]
// Back end: accumulator memory, read-modify-write and result formatting.
`include "assert_macros.svh"

module csb_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  csb_pkg::t_op         i_op,
    input  csb_pkg::t_queue_stat i_qstat,
    output logic                 o_pop,
    output logic                 o_strobe,
    output csb_pkg::t_result     o_result
);

    logic [15:0]              r_acc [csb_pkg::BUFFER_DEPTH];
    logic signed [15:0]       r_rd_data;
    csb_pkg::t_op             r_op;
    csb_pkg::t_back_state     r_state, n_state;
    logic                     r_strobe;
    csb_pkg::t_result         r_result, n_result;

    logic                     exec;
    logic                     wr_en;
    logic signed [15:0]       soft_ext;
    logic signed [15:0]       wr_data;
    logic signed [7:0]        clamped;

    always_comb begin
        case (r_state)
            csb_pkg::BK_IDLE: n_state = i_qstat.empty ? csb_pkg::BK_IDLE : csb_pkg::BK_EXEC;
            csb_pkg::BK_EXEC: n_state = csb_pkg::BK_IDLE;
            default:          n_state = csb_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        exec  = 1'b0;
        case (r_state)
            csb_pkg::BK_IDLE: o_pop = !i_qstat.empty;
            csb_pkg::BK_EXEC: exec  = 1'b1;
            default:          o_pop = 1'b0;
        endcase
    end

    assign soft_ext = {{8{r_op.soft_bit[7]}}, r_op.soft_bit};
    assign wr_en    = exec && (r_op.kind == csb_pkg::OP_WRITE || r_op.kind == csb_pkg::OP_ADD);
    assign wr_data  = (r_op.kind == csb_pkg::OP_ADD) ? r_rd_data + soft_ext : soft_ext;

    always_comb begin
        if (r_rd_data > csb_pkg::SOFT_MAX) begin
            clamped = 8'sd127;
        end else if (r_rd_data < csb_pkg::SOFT_MIN) begin
            clamped = -8'sd127;
        end else begin
            clamped = r_rd_data[7:0];
        end
        n_result.status            = r_op.status;
        n_result.combined_value    = (r_op.kind == csb_pkg::OP_READ) ? clamped : 8'sd0;
        n_result.combine_count     = r_op.count;
        n_result.can_add           = r_op.can_add;
        n_result.transmission_done = r_op.done;
    end

    // The read is issued as the item leaves the queue; the write lands in the cycle after.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_acc[i_op.addr];
            r_op      <= i_op;
        end
        if (wr_en) begin
            r_acc[r_op.addr] <= wr_data;
        end
        if (exec) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= csb_pkg::BK_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= exec;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `CSB_ASSERT_NEXT(a_exec_gives_result, i_clk, i_rst_n, exec, o_strobe, "item gave no result")
    `CSB_ASSERT_SAME(a_no_pop_exec, i_clk, i_rst_n, exec, !o_pop, "pop while busy")

endmodule
